FILE: rtl/core/pdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_pkg: shared types and constants
// Fixed-point format, accumulator widths and the error-history record used by
// the dither requantizer and its channel datapath.
// ----------------------------------------------------------------------------
package pdr_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int SHIFT_BITS = FRAC_BITS - 15;
    localparam int SAMPLE_W   = 32;
    localparam int PCM_W      = 16;
    localparam int ERR_W      = 20;
    localparam int RND_W      = SHIFT_BITS;
    localparam int DITH_W     = RND_W + 1;
    localparam int ACC_W      = SAMPLE_W + 4;

    localparam logic signed [ACC_W-1:0] ONE_VAL  = ACC_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [ACC_W-1:0] HI_VAL   = ACC_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);
    localparam logic signed [ACC_W-1:0] LO_VAL   = ACC_W'(-(64'sd1 <<< FRAC_BITS));
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'sd1 <<< (FRAC_BITS - 16));
    localparam logic signed [ACC_W-1:0] LSB_MASK = ACC_W'((64'sd1 <<< SHIFT_BITS) - 64'sd1);

    localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sh7FFF;
    localparam logic signed [PCM_W-1:0] PCM_MIN = 16'sh8000;

    localparam logic [31:0] LCG_MUL = 32'h0019660D;
    localparam logic [31:0] LCG_ADD = 32'h3C6EF35F;

    typedef enum logic [0:0] {
        REG_DITHER_ENABLE = 1'b0,
        REG_STEREO_MODE   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [ERR_W-1:0] e0;
        logic signed [ERR_W-1:0] e1;
        logic signed [ERR_W-1:0] e2;
    } t_err_hist;

endpackage

FILE: rtl/core/pdr_channel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_channel: one-channel requantizer datapath
// Clip-and-shift conversion, or noise-shaped dithered conversion with the
// next error history; purely combinational.
// ----------------------------------------------------------------------------
module pdr_channel (
    input  logic signed [pdr_pkg::SAMPLE_W-1:0] i_sample,
    input  pdr_pkg::t_err_hist                   i_hist,
    input  logic signed [pdr_pkg::DITH_W-1:0]   i_dither,
    input  logic                                 i_dither_en,
    output logic signed [pdr_pkg::PCM_W-1:0]    o_pcm,
    output pdr_pkg::t_err_hist                   o_hist
);
    import pdr_pkg::*;

    logic signed [ACC_W-1:0] s_ext;
    logic signed [ACC_W-1:0] e0_ext;
    logic signed [ACC_W-1:0] e1_ext;
    logic signed [ACC_W-1:0] e2_ext;
    logic signed [ACC_W-1:0] d_ext;
    logic signed [ACC_W-1:0] s_fb;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] s_clip;
    logic signed [ACC_W-1:0] q_pre;
    logic signed [ACC_W-1:0] q_val;
    logic signed [ACC_W-1:0] err_new;
    logic signed [ACC_W-1:0] q_shift;
    logic signed [ACC_W-1:0] s_shift;
    logic signed [ERR_W:0]   e0_adj;
    logic signed [PCM_W-1:0] fast_pcm;

    assign s_ext  = {{(ACC_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
    assign e0_ext = {{(ACC_W-ERR_W){i_hist.e0[ERR_W-1]}}, i_hist.e0};
    assign e1_ext = {{(ACC_W-ERR_W){i_hist.e1[ERR_W-1]}}, i_hist.e1};
    assign e2_ext = {{(ACC_W-ERR_W){i_hist.e2[ERR_W-1]}}, i_hist.e2};
    assign d_ext  = {{(ACC_W-DITH_W){i_dither[DITH_W-1]}}, i_dither};

    // error feedback and dither
    assign s_fb = s_ext + e0_ext - e1_ext + e2_ext;
    assign sum  = s_fb + HALF_LSB + d_ext;

    always_comb begin
        q_pre  = sum;
        s_clip = s_fb;
        if (sum > HI_VAL) begin
            q_pre = HI_VAL;
            if (s_fb > HI_VAL) begin
                s_clip = HI_VAL;
            end
        end else if (sum < LO_VAL) begin
            q_pre = LO_VAL;
            if (s_fb < LO_VAL) begin
                s_clip = LO_VAL;
            end
        end
    end

    assign q_val   = q_pre & ~LSB_MASK;
    assign err_new = s_clip - q_val;
    assign q_shift = q_val >>> SHIFT_BITS;

    // halve toward zero
    assign e0_adj = {i_hist.e0[ERR_W-1], i_hist.e0}
                  + {{ERR_W{1'b0}}, i_hist.e0[ERR_W-1]};

    assign o_hist.e0 = err_new[ERR_W-1:0];
    assign o_hist.e1 = e0_adj[ERR_W:1];
    assign o_hist.e2 = i_hist.e1;

    assign s_shift = s_ext >>> SHIFT_BITS;

    always_comb begin
        if (s_ext >= ONE_VAL) begin
            fast_pcm = PCM_MAX;
        end else if (s_ext < LO_VAL) begin
            fast_pcm = PCM_MIN;
        end else begin
            fast_pcm = s_shift[PCM_W-1:0];
        end
    end

    assign o_pcm = i_dither_en ? q_shift[PCM_W-1:0] : fast_pcm;

endmodule

FILE: rtl/core/pcm_dither_requantizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_dither_requantizer: stereo fixed-point to 16-bit PCM converter
// Clip-and-shift or noise-shaped dithered requantization of one frame a cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (left/right sample) arrive on i_in_valid / o_in_ready and
//   result words (left/right pcm) leave on o_out_valid / i_out_ready.
//   One word enters per cycle while o_in_ready is high; a word is converted
//   as it moves from the input register into the output register. Sustained
//   rate is one word per cycle while the receiver keeps up; in dithered mode
//   the error histories and the dither generator update as each word moves on.
//   When the receiver stalls, the result holds in the output register and
//   one more word can wait in the input register before o_in_ready drops.
//   Configuration: i_cfg_we writes i_cfg_data[0] to the register at i_cfg_index
//   (0 dither enable, 1 stereo mode); the user must write only while idle, not enforced.
//   Reset (synchronous, active low) empties both registers, clears error
//   histories and the dither generator, selects fast conversion in stereo.
// ----------------------------------------------------------------------------
module pcm_dither_requantizer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [pdr_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic signed [pdr_pkg::SAMPLE_W-1:0] i_right_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [pdr_pkg::PCM_W-1:0]    o_left_pcm,
    output logic signed [pdr_pkg::PCM_W-1:0]    o_right_pcm,
    input  logic                                 i_cfg_we,
    input  logic [0:0]                           i_cfg_index,
    input  logic [0:0]                           i_cfg_data
);
    import pdr_pkg::*;

    logic                       r_in_valid;
    logic signed [SAMPLE_W-1:0] r_left_in;
    logic signed [SAMPLE_W-1:0] r_right_in;
    logic                       r_out_valid;
    logic signed [PCM_W-1:0]    r_left_pcm;
    logic signed [PCM_W-1:0]    r_right_pcm;
    logic                       r_dither_en;
    logic                       r_stereo;
    logic [RND_W-1:0]           r_rnd;
    t_err_hist                  r_left_hist;
    t_err_hist                  r_right_hist;

    logic                       advance;
    logic [RND_W-1:0]           n_rnd;
    logic signed [DITH_W-1:0]   dither;
    logic signed [PCM_W-1:0]    left_pcm;
    logic signed [PCM_W-1:0]    right_pcm;
    t_err_hist                  n_left_hist;
    t_err_hist                  n_right_hist;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // only the low generator bits are kept, so the step runs at that width
    assign n_rnd  = RND_W'(r_rnd * LCG_MUL[RND_W-1:0] + LCG_ADD[RND_W-1:0]);
    assign dither = $signed({1'b0, n_rnd}) - $signed({1'b0, r_rnd});

    pdr_channel u_left (
        .i_sample    (r_left_in),
        .i_hist      (r_left_hist),
        .i_dither    (dither),
        .i_dither_en (r_dither_en),
        .o_pcm       (left_pcm),
        .o_hist      (n_left_hist)
    );

    pdr_channel u_right (
        .i_sample    (r_right_in),
        .i_hist      (r_right_hist),
        .i_dither    (dither),
        .i_dither_en (r_dither_en),
        .o_pcm       (right_pcm),
        .o_hist      (n_right_hist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dither_en <= 1'b0;
            r_stereo    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DITHER_ENABLE: r_dither_en <= i_cfg_data[0];
                REG_STEREO_MODE:   r_stereo    <= i_cfg_data[0];
                default:           r_stereo    <= r_stereo;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_left_in  <= i_left_sample;
            r_right_in <= i_right_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_left_pcm  <= left_pcm;
            r_right_pcm <= r_stereo ? right_pcm : '0;
        end
    end

    // noise-shaping state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd        <= '0;
            r_left_hist  <= '0;
            r_right_hist <= '0;
        end else if (advance && r_dither_en) begin
            r_rnd       <= n_rnd;
            r_left_hist <= n_left_hist;
            if (r_stereo) begin
                r_right_hist <= n_right_hist;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_pcm  = r_left_pcm;
    assign o_right_pcm = r_right_pcm;

`ifndef SYNTHESIS
    a_mono_right_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_stereo |-> o_right_pcm == '0)
        else $error("right word not zero in mono mode");

    a_fast_rnd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_dither_en |=> $stable(r_rnd))
        else $error("dither generator moved in fast mode");

    a_mono_right_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_stereo |=> $stable(r_right_hist))
        else $error("right error history moved in mono mode");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready)
        else $error("input stalled with room in the pipeline");
`endif

endmodule

FILE: test/pcm_dither_requantizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_dither_requantizer_tb: self-checking bench for the dither requantizer
// Feeds stereo sample words through a random-gap driver, rotates the block
// through fast, dithered, stereo and mono settings, and compares every pcm
// word with an in-bench model of clipping, noise shaping and the shared
// dither generator.
// ----------------------------------------------------------------------------
module pcm_dither_requantizer_tb;

    localparam int    SHIFT     = pdr_pkg::SHIFT_BITS;
    localparam longint FULL     = 64'sd1 <<< pdr_pkg::FRAC_BITS;
    localparam longint TOP      = FULL - 64'sd1;
    localparam longint HALF     = 64'sd1 <<< (pdr_pkg::FRAC_BITS - 16);
    localparam longint FRAC_MSK = (64'sd1 <<< SHIFT) - 64'sd1;
    localparam int    CYCLE_LIMIT = 400000;
    localparam int    PHASE_WORDS = 225;

    typedef struct {
        logic signed [pdr_pkg::SAMPLE_W-1:0] left;
        logic signed [pdr_pkg::SAMPLE_W-1:0] right;
    } t_sample_frame;

    typedef struct {
        logic signed [pdr_pkg::PCM_W-1:0] left;
        logic signed [pdr_pkg::PCM_W-1:0] right;
    } t_pcm_frame;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [pdr_pkg::SAMPLE_W-1:0] i_left_sample = '0;
    logic signed [pdr_pkg::SAMPLE_W-1:0] i_right_sample = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [pdr_pkg::PCM_W-1:0] o_left_pcm;
    logic signed [pdr_pkg::PCM_W-1:0] o_right_pcm;
    logic i_cfg_we = 1'b0;
    logic [0:0] i_cfg_index = '0;
    logic [0:0] i_cfg_data = '0;

    t_sample_frame frame_q[$];
    t_pcm_frame    pcm_q[$];
    int  queued_cnt = 0;
    int  accepted_cnt = 0;
    int  fail_cnt = 0;
    int  cycle_cnt = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    bit  calm = 1'b0;

    // model state
    bit          dither_on = 1'b0;
    bit          stereo_on = 1'b1;
    longint      err_hist[2][3];
    logic [31:0] rng_state = '0;

    pcm_dither_requantizer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_left_pcm     (o_left_pcm),
        .o_right_pcm    (o_right_pcm),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [15:0] clip_shift(longint s);
        if (s >= FULL) return pdr_pkg::PCM_MAX;
        if (s < -FULL) return pdr_pkg::PCM_MIN;
        return 16'(s >>> SHIFT);
    endfunction

    function automatic logic signed [15:0] shape_channel(int ch, longint s, longint dith);
        longint v;
        longint frac;
        s = s + err_hist[ch][0] - err_hist[ch][1] + err_hist[ch][2];
        err_hist[ch][2] = err_hist[ch][1];
        err_hist[ch][1] = err_hist[ch][0] / 2;
        v = s + HALF + dith;
        if (v > TOP) begin
            v = TOP;
            if (s > TOP) s = TOP;
        end else if (v < -FULL) begin
            v = -FULL;
            if (s < -FULL) s = -FULL;
        end
        frac = v & FRAC_MSK;
        v = v - frac;
        err_hist[ch][0] = s - v;
        return 16'(v >>> SHIFT);
    endfunction

    function automatic void requantize_frame(t_sample_frame f);
        t_pcm_frame  p;
        logic [31:0] nxt;
        longint      dith;
        p.left = '0;
        p.right = '0;
        if (dither_on) begin
            nxt = rng_state * pdr_pkg::LCG_MUL + pdr_pkg::LCG_ADD;
            nxt = nxt & 32'(FRAC_MSK);
            dith = longint'(nxt) - longint'(rng_state);
            p.left = shape_channel(0, longint'(f.left), dith);
            if (stereo_on) p.right = shape_channel(1, longint'(f.right), dith);
            rng_state = nxt;
        end else begin
            p.left = clip_shift(longint'(f.left));
            if (stereo_on) p.right = clip_shift(longint'(f.right));
        end
        pcm_q.push_back(p);
    endfunction

    function automatic logic signed [31:0] random_sample();
        longint v;
        case ($urandom_range(0, 5))
            0: v = longint'($signed($urandom()));
            1: v = longint'($urandom_range(0, 32'h2000_0000)) - FULL;
            2: v = FULL + longint'($urandom_range(0, 32'h8000)) - 64'sd16384;
            3: v = -FULL + longint'($urandom_range(0, 32'h8000)) - 64'sd16384;
            4: v = longint'($urandom_range(0, 32'hFFFF)) - 64'sd32768;
            default: v = longint'($urandom_range(0, 32'h0800_0000)) - 64'sh0400_0000;
        endcase
        return 32'(v);
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_sample_frame f;
        logic nv;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                f.left = i_left_sample;
                f.right = i_right_sample;
                requantize_frame(f);
                accepted_cnt++;
            end
            nv = i_in_valid && !o_in_ready;
            if (!nv) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (frame_q.size() > 0) begin
                    f = frame_q.pop_front();
                    i_left_sample <= f.left;
                    i_right_sample <= f.right;
                    nv = 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 5);
                end
            end
            i_in_valid <= nv;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pcm_frame p;
        logic rdy;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pcm_q.size() == 0) begin
                    $error("result word with no expectation waiting");
                    fail_cnt++;
                end else begin
                    p = pcm_q.pop_front();
                    if (o_left_pcm !== p.left) begin
                        $error("left_pcm: expected %0d, got %0d", p.left, o_left_pcm);
                        fail_cnt++;
                    end
                    if (o_right_pcm !== p.right) begin
                        $error("right_pcm: expected %0d, got %0d", p.right, o_right_pcm);
                        fail_cnt++;
                    end
                end
            end
            rdy = 1'b1;
            if (out_gap > 0) begin
                out_gap--;
                rdy = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(1, 5);
            end
            i_out_ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(pdr_pkg::t_reg_idx idx, bit val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            pdr_pkg::REG_DITHER_ENABLE: dither_on = val;
            pdr_pkg::REG_STEREO_MODE:   stereo_on = val;
            default: ;
        endcase
    endtask

    task automatic set_mode(bit dith, bit stereo);
        write_reg(pdr_pkg::REG_DITHER_ENABLE, dith);
        write_reg(pdr_pkg::REG_STEREO_MODE, stereo);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_frame(logic signed [31:0] l, logic signed [31:0] r);
        t_sample_frame f;
        f.left = l;
        f.right = r;
        frame_q.push_back(f);
        queued_cnt++;
    endtask

    task automatic drain();
        while (!(accepted_cnt == queued_cnt && pcm_q.size() == 0)) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic signed [31:0] corner[8];
        corner = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1000_0000, 32'sh0FFF_FFFF,
                   32'shF000_0000, 32'shEFFF_FFFF, 32'sh0000_0000, 32'sh0000_1000};
        for (int c = 0; c < 2; c++)
            for (int k = 0; k < 3; k++) err_hist[c][k] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // corner values: fast stereo, dithered stereo, dithered mono
        for (int m = 0; m < 3; m++) begin
            set_mode(m != 0, m != 2);
            for (int i = 0; i < 8; i++) push_frame(corner[i], corner[7 - i]);
            drain();
        end

        for (int ph = 0; ph < 8; ph++) begin
            set_mode(ph[0] ^ 1'b1, ph[1] ^ ph[2] ^ 1'b1);
            if (ph == 7) calm = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) push_frame(random_sample(), random_sample());
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0 && pcm_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
